// File: design/pivot_swaps_to_permutation_macros.svh
// ----------------------------------------------------------------------------
// pivot_swaps_to_permutation_macros
// Assertion macros for the pivot interchange block; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef PIVOT_SWAPS_TO_PERMUTATION_MACROS_SVH
`define PIVOT_SWAPS_TO_PERMUTATION_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define PSP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define PSP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PSP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PSP_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: design/psp_pkg.sv
// ----------------------------------------------------------------------------
// psp_pkg
// Shared constants and types of the pivot interchange block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package psp_pkg;

    localparam int DEF_MAX_ROWS = 64;
    localparam int CNT_W        = 7;   // row_count, row counter
    localparam int PIV_W        = 7;   // pivot_index
    localparam int VAL_W        = 7;   // perm_value
    localparam int CFG_IDX_W    = 8;
    localparam int CFG_DATA_W   = 8;
    localparam int TDATA_W      = 8;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_BASED = 8'd1;

    typedef struct packed {
        logic rd_a_en;
        logic rd_b_en;
        logic wr_en;
        logic clear;
    } t_tbl_ctl;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SWAP_A = 4'b0010,
        ST_SWAP_B = 4'b0100,
        ST_EMIT   = 4'b1000
    } t_state;

endpackage

`default_nettype wire

// File: design/pivot_swaps_to_permutation.sv
// ----------------------------------------------------------------------------
// pivot_swaps_to_permutation
// Turns a row-interchange vector into a permutation vector.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one pivot index per beat for rows 0 .. row_count-1.
//   The configuration channel (i_cfg_*) sets row_count (index 0) and
//   one_based (index 1); o_cfg_ready is always high.
//   A swapping pivot beat is accepted, then written in ST_SWAP_A and
//   ST_SWAP_B through the single write port; a non-swap is only accepted.
//   After the last row's beat, m_axis sends one permutation beat per row
//   (row_count held to 1 .. MAX_ROWS), one per cycle while m_axis_tready
//   is high; each value passes a registered table read, then the output
//   register. tlast marks the final one, tuser flags a bad pivot in the run.
//   s_axis_tready stays low until the final beat sits in the output
//   register. A stall on m_axis holds the output and stops the table walk.
//   After the run the table is the identity again, the row counter and
//   error flag are zero.
//   Reset: identity table, counter 0, row_count 1, zero-based, no output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "pivot_swaps_to_permutation_macros.svh"

module pivot_swaps_to_permutation #(
    parameter int MAX_ROWS = psp_pkg::DEF_MAX_ROWS
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // configuration
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire  [psp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire  [psp_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // pivot stream
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire  [psp_pkg::TDATA_W-1:0]      s_axis_tdata,  // [6:0] pivot_index
    // permutation stream
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    output logic [psp_pkg::TDATA_W-1:0]      m_axis_tdata,  // [6:0] perm_value
    output logic                             m_axis_tlast,
    output logic                             m_axis_tuser   // [0] bad_pivot
);

    localparam int AW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CNT_W = psp_pkg::CNT_W;
    localparam int VAL_W = psp_pkg::VAL_W;

    psp_pkg::t_state   r_state, n_state;
    logic [CNT_W-1:0]  r_row_count;
    logic              r_one_based;
    logic [CNT_W-1:0]  r_row_cnt, n_row_cnt;
    logic              r_err, n_err;
    logic              r_emit, n_emit;
    logic [AW-1:0]     r_row, n_row;
    logic [AW-1:0]     r_target, n_target;
    logic [CNT_W-1:0]  r_iss_k, n_iss_k;
    logic [CNT_W-1:0]  r_rd_k, n_rd_k;
    logic              r_rd_pend, n_rd_pend;
    logic              r_out_valid, n_out_valid;
    logic [VAL_W-1:0]  r_out_val, n_out_val;
    logic              r_out_last, n_out_last;
    logic              r_out_bad, n_out_bad;

    logic [CNT_W-1:0]  rows_m;
    logic [psp_pkg::PIV_W-1:0] pivot;
    logic [psp_pkg::PIV_W-1:0] pivot_m1;
    logic              in_range;
    logic              piv_ok;
    logic [AW-1:0]     target;
    logic              accept;
    logic              do_swap;
    logic              out_free;
    logic              load;
    logic              issue;
    logic              is_last;
    psp_pkg::t_tbl_ctl tbl_ctl;
    logic [AW-1:0]     tbl_rd_a_addr;
    logic [AW-1:0]     tbl_wr_addr;
    logic [AW-1:0]     tbl_wr_data;
    logic [AW-1:0]     tbl_rd_a;
    logic [AW-1:0]     tbl_rd_b;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= CNT_W'(1);
            r_one_based <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                psp_pkg::REG_ROW_COUNT: r_row_count <= i_cfg_data[CNT_W-1:0];
                psp_pkg::REG_ONE_BASED: r_one_based <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // effective row count and pivot check
    always_comb begin
        if (r_row_count == '0) begin
            rows_m = CNT_W'(1);
        end else if (r_row_count > CNT_W'(MAX_ROWS)) begin
            rows_m = CNT_W'(MAX_ROWS);
        end else begin
            rows_m = r_row_count;
        end
    end

    assign pivot    = s_axis_tdata[psp_pkg::PIV_W-1:0];
    assign pivot_m1 = pivot - psp_pkg::PIV_W'(1);
    assign in_range = (r_row_cnt < rows_m);

    always_comb begin
        if (r_one_based) begin
            piv_ok = (pivot != '0) && (pivot <= rows_m);
            target = pivot_m1[AW-1:0];
        end else begin
            piv_ok = (pivot < rows_m);
            target = pivot[AW-1:0];
        end
    end

    assign s_axis_tready = (r_state == psp_pkg::ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign do_swap       = accept && in_range && piv_ok;

    // emit walk
    assign out_free = !r_out_valid || m_axis_tready;
    assign load     = (r_state == psp_pkg::ST_EMIT) && r_rd_pend && out_free;
    assign issue    = (r_state == psp_pkg::ST_EMIT) && (r_iss_k < rows_m)
                      && (!r_rd_pend || out_free);
    assign is_last  = (r_rd_k + CNT_W'(1) == rows_m);

    always_comb begin
        n_state     = r_state;
        n_row_cnt   = r_row_cnt;
        n_err       = r_err;
        n_emit      = r_emit;
        n_row       = r_row;
        n_target    = r_target;
        n_iss_k     = r_iss_k;
        n_rd_k      = r_rd_k;
        n_rd_pend   = r_rd_pend;
        n_out_valid = r_out_valid;
        n_out_val   = r_out_val;
        n_out_last  = r_out_last;
        n_out_bad   = r_out_bad;

        tbl_ctl       = '0;
        tbl_rd_a_addr = r_row_cnt[AW-1:0];
        tbl_wr_addr   = r_row;
        tbl_wr_data   = tbl_rd_b;

        if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            psp_pkg::ST_IDLE: begin
                if (accept) begin
                    n_row_cnt = r_row_cnt + CNT_W'(1);
                    n_row     = r_row_cnt[AW-1:0];
                    n_target  = target;
                    n_emit    = (r_row_cnt + CNT_W'(1) >= rows_m);
                    n_iss_k   = '0;
                    n_rd_pend = 1'b0;
                    if (in_range && !piv_ok) begin
                        n_err = 1'b1;
                    end
                    if (do_swap) begin
                        tbl_ctl.rd_a_en = 1'b1;
                        tbl_ctl.rd_b_en = 1'b1;
                        n_state = psp_pkg::ST_SWAP_A;
                    end else if (r_row_cnt + CNT_W'(1) >= rows_m) begin
                        n_state = psp_pkg::ST_EMIT;
                    end
                end
            end
            psp_pkg::ST_SWAP_A: begin
                tbl_ctl.wr_en = 1'b1;
                tbl_wr_addr   = r_row;
                tbl_wr_data   = tbl_rd_b;
                n_state       = psp_pkg::ST_SWAP_B;
            end
            psp_pkg::ST_SWAP_B: begin
                tbl_ctl.wr_en = 1'b1;
                tbl_wr_addr   = r_target;
                tbl_wr_data   = tbl_rd_a;
                n_state       = r_emit ? psp_pkg::ST_EMIT : psp_pkg::ST_IDLE;
            end
            psp_pkg::ST_EMIT: begin
                tbl_rd_a_addr = r_iss_k[AW-1:0];
                if (issue) begin
                    tbl_ctl.rd_a_en = 1'b1;
                    n_iss_k   = r_iss_k + CNT_W'(1);
                    n_rd_k    = r_iss_k;
                    n_rd_pend = 1'b1;
                end else if (load) begin
                    n_rd_pend = 1'b0;
                end
                if (load) begin
                    n_out_valid = 1'b1;
                    n_out_val   = VAL_W'(tbl_rd_a) + VAL_W'(r_one_based);
                    n_out_last  = is_last;
                    n_out_bad   = r_err;
                    if (is_last) begin
                        tbl_ctl.clear = 1'b1;
                        n_row_cnt     = '0;
                        n_err         = 1'b0;
                        n_state       = psp_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = psp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= psp_pkg::ST_IDLE;
            r_row_cnt   <= '0;
            r_err       <= 1'b0;
            r_emit      <= 1'b0;
            r_iss_k     <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row_cnt   <= n_row_cnt;
            r_err       <= n_err;
            r_emit      <= n_emit;
            r_iss_k     <= n_iss_k;
            r_rd_pend   <= n_rd_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row      <= n_row;
        r_target   <= n_target;
        r_rd_k     <= n_rd_k;
        r_out_val  <= n_out_val;
        r_out_last <= n_out_last;
        r_out_bad  <= n_out_bad;
    end

    psp_table #(
        .MAX_ROWS (MAX_ROWS),
        .AW       (AW)
    ) u_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (tbl_ctl),
        .i_rd_a_addr (tbl_rd_a_addr),
        .i_rd_b_addr (target),
        .i_wr_addr   (tbl_wr_addr),
        .i_wr_data   (tbl_wr_data),
        .o_rd_a      (tbl_rd_a),
        .o_rd_b      (tbl_rd_b)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(psp_pkg::TDATA_W-VAL_W){1'b0}}, r_out_val};
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_bad;

    `PSP_ASSERT_IMP(a_row_cnt_bound, i_clk, i_rst_n, 1'b1, r_row_cnt <= CNT_W'(MAX_ROWS))
    `PSP_ASSERT_IMP(a_issue_bound, i_clk, i_rst_n, r_state == psp_pkg::ST_EMIT,
                    r_iss_k <= rows_m)
    `PSP_ASSERT_NXT(a_swap_start, i_clk, i_rst_n, do_swap,
                    r_state == psp_pkg::ST_SWAP_A)
    `PSP_ASSERT_NXT(a_run_end, i_clk, i_rst_n, load && is_last,
                    r_state == psp_pkg::ST_IDLE && r_row_cnt == '0 && !r_err
                    && m_axis_tvalid && m_axis_tlast)

endmodule

`default_nettype wire

// File: design/psp_table.sv
// ----------------------------------------------------------------------------
// psp_table
// Permutation table: one write port, two registered read ports, per-entry
// valid bits. An entry that is not valid reads as its own index.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module psp_table #(
    parameter int MAX_ROWS = psp_pkg::DEF_MAX_ROWS,
    parameter int AW       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  psp_pkg::t_tbl_ctl    i_ctl,
    input  wire  [AW-1:0]        i_rd_a_addr,
    input  wire  [AW-1:0]        i_rd_b_addr,
    input  wire  [AW-1:0]        i_wr_addr,
    input  wire  [AW-1:0]        i_wr_data,
    output logic [AW-1:0]        o_rd_a,
    output logic [AW-1:0]        o_rd_b
);

    logic [AW-1:0]       r_mem [MAX_ROWS];
    logic [MAX_ROWS-1:0] r_valid;
    logic [AW-1:0]       r_rd_a;
    logic [AW-1:0]       r_rd_b;
    logic [AW-1:0]       r_rd_a_addr;
    logic [AW-1:0]       r_rd_b_addr;
    logic                r_rd_a_v;
    logic                r_rd_b_v;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_a_en) begin
            r_rd_a      <= r_mem[i_rd_a_addr];
            r_rd_a_addr <= i_rd_a_addr;
            r_rd_a_v    <= r_valid[i_rd_a_addr];
        end
        if (i_ctl.rd_b_en) begin
            r_rd_b      <= r_mem[i_rd_b_addr];
            r_rd_b_addr <= i_rd_b_addr;
            r_rd_b_v    <= r_valid[i_rd_b_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_ctl.clear) begin
            r_valid <= '0;
        end else if (i_ctl.wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    assign o_rd_a = r_rd_a_v ? r_rd_a : r_rd_a_addr;
    assign o_rd_b = r_rd_b_v ? r_rd_b : r_rd_b_addr;

endmodule

`default_nettype wire
